### src/selu_pkg.sv
// ----------------------------------------------------------------------------
// selu_pkg
// shared constants and types for the selu activation unit
// ----------------------------------------------------------------------------
package selu_pkg;

  localparam int unsigned COEF_W = 16;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_ALPHA  = 2'd0,
    REG_LAMBDA = 2'd1
  } selu_reg_e;

  localparam logic [COEF_W-1:0] ALPHA_RESET  = 16'd6854;
  localparam logic [COEF_W-1:0] LAMBDA_RESET = 16'd4304;

  // log2(e) in q.16
  localparam logic [16:0] LOG2E_Q16 = 17'd94548;

  // 1.0 in q.16
  localparam logic [16:0] EXP_ONE = 17'd65536;

  // round(65536 * 2^(-j/16)) for j = 0..16
  localparam logic [16:0] POW2_NEG_TAB [17] = '{
    17'd65536, 17'd62757, 17'd60097, 17'd57549, 17'd55109, 17'd52773,
    17'd50535, 17'd48393, 17'd46341, 17'd44376, 17'd42495, 17'd40693,
    17'd38968, 17'd37316, 17'd35734, 17'd34219, 17'd32768
  };

endpackage

### src/selu_activation_unit_core.sv
// ----------------------------------------------------------------------------
// selu_activation_unit_core
// pipelined selu activation: x * lambda for x >= 0, (exp(x) - 1) * alpha *
// lambda for x < 0, rounded and saturated to the sample format
// ----------------------------------------------------------------------------
// result strobe: registered in stage 6 for each accepted item, after stages 1 to 5
// throughput: one item per cycle, busy_o stays low, set by the six-stage pipeline
// reset: pipeline valid bits clear, alpha and lambda return to 1.6733 and 1.0507
// the receiver cannot stall, so every stage advances on every clock
module selu_activation_unit_core #(
  parameter int unsigned DATA_WIDTH = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration write port
  input  logic                               cfg_we_i,
  input  logic [1:0]                         cfg_idx_i,
  input  logic [selu_pkg::COEF_W-1:0]        cfg_wdata_i,
  // command side
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic signed [DATA_WIDTH-1:0]       sample_in_i,
  input  logic                               last_in_i,
  // result side
  output logic                               result_valid_o,
  output logic signed [DATA_WIDTH-1:0]       sample_out_o,
  output logic                               saturated_o,
  output logic                               last_out_o
);

  localparam int unsigned CW = selu_pkg::COEF_W;
  // width of |x| * log2(e)
  localparam int unsigned MW = DATA_WIDTH + 17;
  // width of |x| * lambda
  localparam int unsigned PW = DATA_WIDTH + CW;
  // width of the rounded positive result
  localparam int unsigned YW = PW - 11;
  localparam logic [YW-1:0] POS_MAX =
    YW'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);
  localparam logic [32:0] NEG_MAX = 33'(64'd1 << (DATA_WIDTH - 1));

  // --------------------------------------------------------------------------
  // configuration registers and the alpha * lambda product
  // --------------------------------------------------------------------------
  logic [CW-1:0]   alpha_q, lambda_q;
  logic [2*CW-1:0] al_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q  <= selu_pkg::ALPHA_RESET;
      lambda_q <= selu_pkg::LAMBDA_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        selu_pkg::REG_ALPHA:  alpha_q  <= cfg_wdata_i;
        selu_pkg::REG_LAMBDA: lambda_q <= cfg_wdata_i;
        default: ; // unknown index, write dropped
      endcase
    end
  end

  // only used from stage 5 on, so the lag of this register after a write is hidden
  always_ff @(posedge clk_i) begin
    al_q <= alpha_q * lambda_q;
  end

  // no back-pressure anywhere
  assign busy_o = 1'b0;

  logic accept;
  assign accept = start_i && !busy_o;

  // --------------------------------------------------------------------------
  // valid bits, one per stage
  // --------------------------------------------------------------------------
  logic [4:0] vld_q;
  logic       out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      vld_q     <= {vld_q[3:0], accept};
      out_vld_q <= vld_q[4];
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: sign and magnitude
  // --------------------------------------------------------------------------
  logic                  s1_neg_q, s1_last_q;
  logic [DATA_WIDTH-1:0] s1_mag_q;
  logic                  in_neg;

  assign in_neg = sample_in_i[DATA_WIDTH-1];

  always_ff @(posedge clk_i) begin
    s1_neg_q  <= in_neg;
    s1_last_q <= last_in_i;
    // the most negative sample maps to 2^(w-1), which still fits unsigned
    s1_mag_q  <= in_neg ? (~sample_in_i + DATA_WIDTH'(1)) : sample_in_i;
  end

  // --------------------------------------------------------------------------
  // stage 2: the two multiplies, |x| * log2(e) and |x| * lambda
  // --------------------------------------------------------------------------
  logic          s2_neg_q, s2_last_q;
  logic [MW-1:0] s2_m_q;
  logic [PW-1:0] s2_pos_q;

  always_ff @(posedge clk_i) begin
    s2_neg_q  <= s1_neg_q;
    s2_last_q <= s1_last_q;
    s2_m_q    <= s1_mag_q * selu_pkg::LOG2E_Q16;
    s2_pos_q  <= s1_mag_q * lambda_q;
  end

  // --------------------------------------------------------------------------
  // stage 3: positive rounding and saturation; table lookup and slope * frac
  // --------------------------------------------------------------------------
  logic [YW-1:0]  pos_y;
  logic [3:0]     tab_j;
  logic [19:0]    tab_f;
  logic [16:0]    tab_hi, tab_lo, tab_d;
  logic [31:0]    shift_full;

  assign pos_y      = YW'((PW + 1)'(s2_pos_q) + (PW + 1)'(2048) >> 12);
  assign tab_j      = s2_m_q[23:20];
  assign tab_f      = s2_m_q[19:0];
  assign tab_hi     = selu_pkg::POW2_NEG_TAB[{1'b0, tab_j}];
  assign tab_lo     = selu_pkg::POW2_NEG_TAB[{1'b0, tab_j} + 5'd1];
  assign tab_d      = tab_hi - tab_lo;
  // integer part of |x| * log2(e) is the right shift of the interpolated value
  assign shift_full = 32'(s2_m_q[MW-1:24]);

  logic                  s3_neg_q, s3_last_q, s3_pos_sat_q, s3_zero_q;
  logic [DATA_WIDTH-1:0] s3_pos_res_q;
  logic [16:0]           s3_hi_q;
  logic [36:0]           s3_df_q;
  logic [4:0]            s3_sh_q;

  always_ff @(posedge clk_i) begin
    s3_neg_q     <= s2_neg_q;
    s3_last_q    <= s2_last_q;
    s3_pos_sat_q <= pos_y > POS_MAX;
    s3_pos_res_q <= (pos_y > POS_MAX) ? DATA_WIDTH'(POS_MAX) : DATA_WIDTH'(pos_y);
    s3_hi_q      <= tab_hi;
    s3_df_q      <= tab_d * tab_f;
    // exp underflows to zero beyond a shift of 16
    s3_zero_q    <= shift_full > 32'd16;
    s3_sh_q      <= shift_full[4:0];
  end

  // --------------------------------------------------------------------------
  // stage 4: interpolated 2^-frac, shifted by the integer part, 1 - exp
  // --------------------------------------------------------------------------
  logic [17:0] interp_corr;
  logic [16:0] interp_v, exp_e;

  assign interp_corr = 18'((38'(s3_df_q) + 38'(1 << 19)) >> 20);
  assign interp_v    = s3_hi_q - 17'(interp_corr);
  assign exp_e       = s3_zero_q ? 17'd0 : (interp_v >> s3_sh_q);

  logic                  s4_neg_q, s4_last_q, s4_pos_sat_q;
  logic [DATA_WIDTH-1:0] s4_pos_res_q;
  logic [16:0]           s4_ome_q;

  always_ff @(posedge clk_i) begin
    s4_neg_q     <= s3_neg_q;
    s4_last_q    <= s3_last_q;
    s4_pos_sat_q <= s3_pos_sat_q;
    s4_pos_res_q <= s3_pos_res_q;
    s4_ome_q     <= selu_pkg::EXP_ONE - exp_e;
  end

  // --------------------------------------------------------------------------
  // stage 5: (1 - exp) * alpha * lambda
  // --------------------------------------------------------------------------
  logic                  s5_neg_q, s5_last_q, s5_pos_sat_q;
  logic [DATA_WIDTH-1:0] s5_pos_res_q;
  logic [48:0]           s5_prod_q;

  always_ff @(posedge clk_i) begin
    s5_neg_q     <= s4_neg_q;
    s5_last_q    <= s4_last_q;
    s5_pos_sat_q <= s4_pos_sat_q;
    s5_pos_res_q <= s4_pos_res_q;
    s5_prod_q    <= s4_ome_q * al_q;
  end

  // --------------------------------------------------------------------------
  // stage 6: negative rounding, saturation, negate and path select
  // --------------------------------------------------------------------------
  logic [17:0] neg_mag;
  logic        neg_sat;
  logic [32:0] neg_mag_sat;

  assign neg_mag     = 18'((50'(s5_prod_q) + 50'(64'd1 << 31)) >> 32);
  assign neg_sat     = 33'(neg_mag) > NEG_MAX;
  assign neg_mag_sat = neg_sat ? NEG_MAX : 33'(neg_mag);

  logic signed [DATA_WIDTH-1:0] out_sample_q;
  logic                         out_sat_q, out_last_q;

  always_ff @(posedge clk_i) begin
    out_last_q <= s5_last_q;
    if (s5_neg_q) begin
      out_sample_q <= DATA_WIDTH'(33'd0 - neg_mag_sat);
      out_sat_q    <= neg_sat;
    end else begin
      out_sample_q <= s5_pos_res_q;
      out_sat_q    <= s5_pos_sat_q;
    end
  end

  assign result_valid_o = out_vld_q;
  assign sample_out_o   = out_sample_q;
  assign saturated_o    = out_sat_q;
  assign last_out_o     = out_last_q;

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for selu_activation_unit_core: drives signed q8.8
// samples with random gaps, recomputes each selu result with a bit-accurate
// fixed-point predictor and compares every strobed result in order
// ----------------------------------------------------------------------------
module tb;

  localparam int DW             = 16;
  localparam int CW             = selu_pkg::COEF_W;
  localparam int HALF_PERIOD    = 10;
  localparam int RESET_CYCLES   = 8;
  // extra wait after the last result, as margin before touching registers
  localparam int DRAIN_CYCLES   = 12;
  // cycles with no item accepted, no result and no register write
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_ITEMS    = 116;

  // register indexes that decode to nothing
  localparam logic [1:0] IDX_SPARE_A = 2'd2;
  localparam logic [1:0] IDX_SPARE_B = 2'd3;

  // log2(e) in q.16 and round(65536 * 2^(-j/16)), j = 0..16
  localparam bit [63:0] LOG2E_FIX = 64'd94548;
  localparam bit [16:0] EXP2_FRAC [17] = '{
    17'd65536, 17'd62757, 17'd60097, 17'd57549, 17'd55109, 17'd52773,
    17'd50535, 17'd48393, 17'd46341, 17'd44376, 17'd42495, 17'd40693,
    17'd38968, 17'd37316, 17'd35734, 17'd34219, 17'd32768
  };

  typedef struct packed {
    logic signed [DW-1:0] y;
    logic                 sat;
    logic                 last;
  } selu_res_t;

  // keeps its own copy of alpha and lambda, predicts one result per item
  // and holds the predictions in arrival order
  class selu_tracker;
    bit [15:0] alpha  = 16'd6854;
    bit [15:0] lambda = 16'd4304;
    selu_res_t awaited [$];
    int        fails = 0;

    function void set_coef(logic [1:0] idx, logic [15:0] val);
      if (idx == selu_pkg::REG_ALPHA) alpha = val;
      else if (idx == selu_pkg::REG_LAMBDA) lambda = val;
    endfunction

    function selu_res_t selu_of(logic [DW-1:0] x, logic last);
      bit [63:0]   mag, m, q, g, f, hi, lo, v, e, al, prod, y;
      int unsigned j;
      selu_res_t   r;
      r.sat  = 1'b0;
      r.last = last;
      if (x[DW-1]) begin
        // exp(x) = 2^-q * 2^-g, fraction by table plus linear step
        mag  = (64'd1 << DW) - x;
        m    = mag * LOG2E_FIX;
        q    = m >> 24;
        g    = m & 64'hFF_FFFF;
        j    = g[23:20];
        f    = g & 64'hF_FFFF;
        hi   = EXP2_FRAC[j];
        lo   = EXP2_FRAC[j + 1];
        v    = hi - ((((hi - lo) * f) + (64'd1 << 19)) >> 20);
        e    = (q > 16) ? 64'd0 : (v >> q);
        al   = alpha * lambda;
        prod = (64'd65536 - e) * al;
        y    = (prod + (64'd1 << 31)) >> 32;
        if (y > (64'd1 << (DW - 1))) begin
          y     = 64'd1 << (DW - 1);
          r.sat = 1'b1;
        end
        r.y = DW'(64'd0 - y);
      end else begin
        prod = x * lambda;
        y    = (prod + 64'd2048) >> 12;
        if (y > (64'd1 << (DW - 1)) - 1) begin
          y     = (64'd1 << (DW - 1)) - 1;
          r.sat = 1'b1;
        end
        r.y = DW'(y);
      end
      return r;
    endfunction

    function void note_item(logic [DW-1:0] x, logic last);
      awaited.push_back(selu_of(x, last));
    endfunction

    function void check_result(logic signed [DW-1:0] y, logic sat, logic last);
      selu_res_t want;
      if (awaited.size() == 0) begin
        $error("unexpected result: sample_out %0d saturated %b last_out %b", y, sat, last);
        fails++;
        return;
      end
      want = awaited.pop_front();
      if (y !== want.y) begin
        $error("sample_out: expected %0d, actual %0d", want.y, y);
        fails++;
      end
      if (sat !== want.sat) begin
        $error("saturated: expected %b, actual %b", want.sat, sat);
        fails++;
      end
      if (last !== want.last) begin
        $error("last_out: expected %b, actual %b", want.last, last);
        fails++;
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [1:0]           cfg_idx_i;
  logic [CW-1:0]        cfg_wdata_i;
  logic                 start_i;
  logic                 busy_o;
  logic signed [DW-1:0] sample_in_i;
  logic                 last_in_i;
  logic                 result_valid_o;
  logic signed [DW-1:0] sample_out_o;
  logic                 saturated_o;
  logic                 last_out_o;

  selu_tracker sb;
  int          quiet_cycles = 0;

  selu_activation_unit_core #(
    .DATA_WIDTH (DW)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .sample_in_i    (sample_in_i),
    .last_in_i      (last_in_i),
    .result_valid_o (result_valid_o),
    .sample_out_o   (sample_out_o),
    .saturated_o    (saturated_o),
    .last_out_o     (last_out_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #HALF_PERIOD clk_i = ~clk_i;
  end

  // results cannot be held off, so every strobe is checked at the edge
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && result_valid_o === 1'b1) begin
      sb.check_result(sample_out_o, saturated_o, last_out_o);
    end
  end

  // progress means an item accepted, a result strobed or a register written
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if ((start_i && !busy_o) || result_valid_o || cfg_we_i) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // present one item at the falling edge and hold it until the block takes it
  task automatic send_sample(input logic [DW-1:0] x, input logic last);
    @(negedge clk_i);
    start_i     <= 1'b1;
    sample_in_i <= x;
    last_in_i   <= last;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    sb.note_item(x, last);
  endtask

  // sender gap: start low, payload wiggles as noise
  task automatic pause_cycles(input int n);
    repeat (n) begin
      @(negedge clk_i);
      start_i     <= 1'b0;
      sample_in_i <= DW'($urandom);
      last_in_i   <= 1'($urandom);
    end
  endtask

  task automatic write_coef(input logic [1:0] idx, input logic [CW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    sb.set_coef(idx, val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= CW'($urandom);
  endtask

  // stop sending, let every prediction be matched, then let the pipe settle
  task automatic wait_idle();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [CW-1:0] rand_coef();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return '1;
      default: return CW'($urandom);
    endcase
  endfunction

  // mix of full-range values and the regions where the math is interesting
  function automatic logic [DW-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return DW'($urandom);
      // negative samples inside the useful exp range
      4, 5, 6:    return DW'(0 - int'($urandom_range(1, 3100)));
      7:          return DW'($urandom_range(0, 1000));
      // close to positive clipping
      8:          return DW'($urandom_range(30000, 32767));
      // most negative corner
      default:    return DW'(16'h8000 + $urandom_range(0, 300));
    endcase
  endfunction

  task automatic run_phase(input int n, input bit gaps);
    for (int i = 0; i < n; i++) begin
      if (gaps && $urandom_range(0, 3) == 0) pause_cycles($urandom_range(1, 14));
      send_sample(rand_sample(), 1'($urandom));
    end
  endtask

  initial begin
    sb          = new;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_wdata_i = '0;
    start_i     = 1'b0;
    sample_in_i = '0;
    last_in_i   = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset coefficients: zero, unit steps, both extremes, exp cutoff around q = 16
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd1, 1'b0);
    send_sample(-16'sd1, 1'b1);
    send_sample(16'sd256, 1'b0);
    send_sample(-16'sd256, 1'b0);
    send_sample(16'sd32767, 1'b0);
    send_sample(16'h8000, 1'b1);
    send_sample(-16'sd2839, 1'b0);
    send_sample(-16'sd2840, 1'b0);
    send_sample(-16'sd3016, 1'b1);
    send_sample(-16'sd3017, 1'b0);
    send_sample(16'sd12345, 1'b1);
    wait_idle();

    // largest coefficients: negative clipping and positive clipping
    write_coef(selu_pkg::REG_ALPHA, '1);
    write_coef(selu_pkg::REG_LAMBDA, '1);
    send_sample(16'h8000, 1'b0);
    send_sample(-16'sd1, 1'b0);
    send_sample(16'sd32767, 1'b1);
    send_sample(16'sd1, 1'b0);
    send_sample(16'sd0, 1'b1);
    wait_idle();

    // zero coefficients
    write_coef(selu_pkg::REG_ALPHA, '0);
    write_coef(selu_pkg::REG_LAMBDA, '0);
    send_sample(-16'sd5, 1'b0);
    send_sample(16'sd77, 1'b1);
    wait_idle();

    // writes to undecoded indexes must leave both coefficients at zero
    write_coef(IDX_SPARE_A, 16'h1234);
    write_coef(IDX_SPARE_B, 16'hFFFF);
    send_sample(-16'sd256, 1'b1);
    send_sample(16'sd256, 1'b0);
    wait_idle();

    // random phases, each with fresh coefficients; the last one runs gap-free
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_coef(selu_pkg::REG_ALPHA, rand_coef());
      write_coef(selu_pkg::REG_LAMBDA, rand_coef());
      if ($urandom_range(0, 3) == 0) begin
        write_coef($urandom_range(0, 1) ? IDX_SPARE_A : IDX_SPARE_B, CW'($urandom));
      end
      run_phase(PHASE_ITEMS, (p < RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0));
      wait_idle();
    end

    if (sb.fails == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
